// ----- rtl/i2c_trb_pkg.sv -----
// Shared constants, codes and types for the I2C target register bank.
package i2c_trb_pkg;

    localparam int BANK_SIZE_DEF = 256;

    localparam int OP_W   = 3;
    localparam int BYTE_W = 8;
    localparam int ST_W   = 3;
    // pointer (8 bits) plus offset, with headroom for a sign bit
    localparam int SUM_W  = 10;

    localparam logic [OP_W-1:0] OP_ADDR_WR  = 3'd0;
    localparam logic [OP_W-1:0] OP_ADDR_RD  = 3'd1;
    localparam logic [OP_W-1:0] OP_BYTE_RX  = 3'd2;
    localparam logic [OP_W-1:0] OP_BYTE_TX  = 3'd3;
    localparam logic [OP_W-1:0] OP_NACK_END = 3'd4;
    localparam logic [OP_W-1:0] OP_BUS_ERR  = 3'd5;

    localparam logic [ST_W-1:0] ST_NONE      = 3'd0;
    localparam logic [ST_W-1:0] ST_COMMIT    = 3'd1;
    localparam logic [ST_W-1:0] ST_REJECT    = 3'd2;
    localparam logic [ST_W-1:0] ST_READ_DONE = 3'd3;
    localparam logic [ST_W-1:0] ST_BUS_ERR   = 3'd4;
    localparam logic [ST_W-1:0] ST_IGNORED   = 3'd5;

    typedef struct packed {
        logic              en;
        logic [BYTE_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } mem_wr_t;

    typedef struct packed {
        logic              en;
        logic [BYTE_W-1:0] addr;
    } mem_rd_t;

    typedef struct packed {
        logic [BYTE_W-1:0] read_data;
        logic              read_valid;
        logic [ST_W-1:0]   status;
    } result_t;

endpackage

// ----- rtl/i2c_trb_in_if.sv -----
// Input channel: one bus event per item.
interface i2c_trb_in_if;
    import i2c_trb_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [BYTE_W-1:0] data;

    modport source (output valid, output operation, output data, input ready);
    modport sink   (input valid, input operation, input data, output ready);
endinterface

// ----- rtl/i2c_trb_out_if.sv -----
// Output channel: one result per item.
interface i2c_trb_out_if;
    import i2c_trb_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] read_data;
    logic              read_valid;
    logic [ST_W-1:0]   status;

    modport source (output valid, output read_data, output read_valid, output status,
                    input ready);
    modport sink   (input valid, input read_data, input read_valid, input status,
                    output ready);
endinterface

// ----- rtl/i2c_target_register_bank_top.sv -----
// Top level of the I2C target register bank.
// Byte-event front end for an I2C target with BANK_SIZE 8-bit registers and an 8-bit
// register pointer. Each item is one bus event and yields exactly one result. The block
// handles one item at a time. An address read or a byte sent reduces the address in the
// shared adder, which subtracts the bank size once a cycle until it is in range, and then
// reads the bank; a write commit copies the data bytes into the bank in turn, paced by the
// single write port of the bank. A finished result sits in an output register, so the next
// item is taken while it waits. Registers read as zero until written; no clearing pass is
// needed after reset.
module i2c_target_register_bank_top #(
    parameter int BANK_SIZE = i2c_trb_pkg::BANK_SIZE_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    i2c_trb_in_if.sink    req,
    i2c_trb_out_if.source rsp
);
    import i2c_trb_pkg::*;

    mem_wr_t           bank_wr;
    mem_rd_t           bank_rd;
    mem_wr_t           pend_wr;
    mem_rd_t           pend_rd;
    logic [BYTE_W-1:0] bank_q;
    logic [BYTE_W-1:0] pend_q;

    i2c_trb_ctrl #(
        .BANK_SIZE (BANK_SIZE)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .bank_wr (bank_wr),
        .bank_rd (bank_rd),
        .bank_q  (bank_q),
        .pend_wr (pend_wr),
        .pend_rd (pend_rd),
        .pend_q  (pend_q)
    );

    i2c_trb_bank #(
        .BANK_SIZE (BANK_SIZE)
    ) u_bank (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (bank_wr),
        .rd    (bank_rd),
        .q     (bank_q)
    );

    i2c_trb_pend #(
        .BANK_SIZE (BANK_SIZE)
    ) u_pend (
        .clk (clk),
        .wr  (pend_wr),
        .rd  (pend_rd),
        .q   (pend_q)
    );

    // one item in flight: ready drops right after an accept
    ap_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("item accepted while another is in progress");

    ap_bank_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(bank_wr.en && bank_rd.en))
        else $error("bank read and commit write in the same cycle");

    ap_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
        bank_wr.en |-> ({1'b0, bank_wr.addr} < 9'(BANK_SIZE)))
        else $error("commit write past the end of the bank");

endmodule

// ----- rtl/i2c_trb_bank.sv -----
// Register bank memory with per-entry valid bits; unwritten entries read as zero.
module i2c_trb_bank #(
    parameter int BANK_SIZE = i2c_trb_pkg::BANK_SIZE_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  i2c_trb_pkg::mem_wr_t     wr,
    input  i2c_trb_pkg::mem_rd_t     rd,
    output logic [i2c_trb_pkg::BYTE_W-1:0] q
);
    import i2c_trb_pkg::*;

    localparam int AW = (BANK_SIZE > 1) ? $clog2(BANK_SIZE) : 1;

    logic [BYTE_W-1:0]    mem_reg [BANK_SIZE];
    logic [BANK_SIZE-1:0] vld_reg;
    logic [BYTE_W-1:0]    mem_q_reg;
    logic                 hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            hit_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                vld_reg[wr.addr[AW-1:0]] <= 1'b1;
            end
            if (rd.en)
            begin
                hit_reg <= vld_reg[rd.addr[AW-1:0]];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem_reg[wr.addr[AW-1:0]] <= wr.data;
        end
        if (rd.en)
        begin
            mem_q_reg <= mem_reg[rd.addr[AW-1:0]];
        end
    end

    assign q = hit_reg ? mem_q_reg : '0;

endmodule

// ----- rtl/i2c_trb_pend.sv -----
// Buffer for the data bytes of a write transfer.
module i2c_trb_pend #(
    parameter int BANK_SIZE = i2c_trb_pkg::BANK_SIZE_DEF
) (
    input  logic                     clk,
    input  i2c_trb_pkg::mem_wr_t     wr,
    input  i2c_trb_pkg::mem_rd_t     rd,
    output logic [i2c_trb_pkg::BYTE_W-1:0] q
);
    import i2c_trb_pkg::*;

    localparam int AW = (BANK_SIZE > 1) ? $clog2(BANK_SIZE) : 1;

    logic [BYTE_W-1:0] mem_reg [BANK_SIZE];
    logic [BYTE_W-1:0] q_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem_reg[wr.addr[AW-1:0]] <= wr.data;
        end
        if (rd.en)
        begin
            q_reg <= mem_reg[rd.addr[AW-1:0]];
        end
    end

    assign q = q_reg;

endmodule

// ----- rtl/i2c_trb_ctrl.sv -----
// Sequencer with one shared adder: pointer wrap, range check and commit copy.
module i2c_trb_ctrl #(
    parameter int BANK_SIZE = i2c_trb_pkg::BANK_SIZE_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    i2c_trb_in_if.sink               req,
    i2c_trb_out_if.source            rsp,
    output i2c_trb_pkg::mem_wr_t     bank_wr,
    output i2c_trb_pkg::mem_rd_t     bank_rd,
    input  logic [i2c_trb_pkg::BYTE_W-1:0] bank_q,
    output i2c_trb_pkg::mem_wr_t     pend_wr,
    output i2c_trb_pkg::mem_rd_t     pend_rd,
    input  logic [i2c_trb_pkg::BYTE_W-1:0] pend_q
);
    import i2c_trb_pkg::*;

    localparam int AW = (BANK_SIZE > 1) ? $clog2(BANK_SIZE) : 1;
    localparam int CW = $clog2(BANK_SIZE + 1);
    localparam logic [SUM_W-1:0] NEG_BS = SUM_W'(-BANK_SIZE);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MOD  = 3'd1;
    localparam logic [2:0] S_RDW  = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_COPY = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic              writes_reg, writes_next;
    logic [BYTE_W-1:0] ptr_reg, ptr_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [CW-1:0]     sent_reg, sent_next;
    logic [AW-1:0]     base_mod_reg, base_mod_next;
    logic              load_base_reg, load_base_next;
    logic              out_valid_reg, out_valid_next;
    logic              cp_wr_reg, cp_wr_next;
    logic [SUM_W-1:0]  acc_reg, acc_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic [AW-1:0]     last_reg, last_next;
    logic [BYTE_W-1:0] cp_addr_reg, cp_addr_next;
    result_t           res_reg, res_next;
    result_t           out_reg, out_next;

    logic [SUM_W-1:0]  alu_a, alu_b, alu_sum;
    logic [CW-1:0]     cnt_inc, sent_inc;

    assign alu_sum  = alu_a + alu_b;
    assign cnt_inc  = cnt_reg + 1'b1;
    assign sent_inc = sent_reg + 1'b1;

    assign req.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.read_data  = out_reg.read_data;
    assign rsp.read_valid = out_reg.read_valid;
    assign rsp.status     = out_reg.status;

    // copy writes come in the cycle after their buffer read
    assign bank_wr.en   = cp_wr_reg;
    assign bank_wr.addr = cp_addr_reg;
    assign bank_wr.data = pend_q;

    always_comb
    begin
        state_next     = state_reg;
        writes_next    = writes_reg;
        ptr_next       = ptr_reg;
        cnt_next       = cnt_reg;
        sent_next      = sent_reg;
        base_mod_next  = base_mod_reg;
        load_base_next = load_base_reg;
        acc_next       = acc_reg;
        idx_next       = idx_reg;
        last_next      = last_reg;
        cp_addr_next   = cp_addr_reg;
        cp_wr_next     = 1'b0;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        bank_rd        = '0;
        pend_wr        = '0;
        pend_rd        = '0;
        alu_a          = '0;
        alu_b          = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                alu_a = SUM_W'(base_mod_reg);
                alu_b = SUM_W'(sent_inc);
                if (req.valid)
                begin
                    res_next   = '0;
                    state_next = S_EMIT;
                    unique case (req.operation)
                        OP_ADDR_WR:
                        begin
                            writes_next = 1'b1;
                            ptr_next    = '0;
                            cnt_next    = '0;
                        end
                        OP_ADDR_RD:
                        begin
                            writes_next    = 1'b0;
                            ptr_next       = '0;
                            sent_next      = '0;
                            acc_next       = SUM_W'(ptr_reg);
                            load_base_next = 1'b1;
                            state_next     = S_MOD;
                        end
                        OP_BYTE_RX:
                        begin
                            if (!writes_reg || cnt_reg >= CW'(BANK_SIZE))
                            begin
                                res_next.status = ST_IGNORED;
                            end
                            else
                            begin
                                // first byte is the pointer, kept in its own register
                                if (cnt_reg == '0)
                                begin
                                    ptr_next = req.data;
                                end
                                else
                                begin
                                    pend_wr.en   = 1'b1;
                                    pend_wr.addr = BYTE_W'(cnt_reg);
                                    pend_wr.data = req.data;
                                end
                                cnt_next = cnt_inc;
                                if (cnt_inc == CW'(BANK_SIZE))
                                begin
                                    state_next = S_CHK;
                                end
                            end
                        end
                        OP_BYTE_TX:
                        begin
                            if (writes_reg)
                            begin
                                res_next.status = ST_IGNORED;
                            end
                            else if (sent_inc < CW'(BANK_SIZE))
                            begin
                                sent_next      = sent_inc;
                                acc_next       = alu_sum;
                                load_base_next = 1'b0;
                                state_next     = S_MOD;
                            end
                            else
                            begin
                                sent_next       = '0;
                                res_next.status = ST_READ_DONE;
                            end
                        end
                        OP_NACK_END:
                        begin
                            if (writes_reg)
                            begin
                                state_next = S_CHK;
                            end
                            else
                            begin
                                sent_next       = '0;
                                res_next.status = ST_READ_DONE;
                            end
                        end
                        OP_BUS_ERR:
                        begin
                            ptr_next        = '0;
                            cnt_next        = '0;
                            res_next.status = ST_BUS_ERR;
                        end
                        default:
                        begin
                            res_next.status = ST_NONE;
                        end
                    endcase
                end
            end
            S_MOD:
            begin
                // subtract the bank size until the address is in range
                alu_a = acc_reg;
                alu_b = NEG_BS;
                if (!alu_sum[SUM_W-1])
                begin
                    acc_next = alu_sum;
                end
                else
                begin
                    bank_rd.en   = 1'b1;
                    bank_rd.addr = BYTE_W'(acc_reg);
                    if (load_base_reg)
                    begin
                        base_mod_next = AW'(acc_reg);
                    end
                    state_next = S_RDW;
                end
            end
            S_RDW:
            begin
                res_next.read_data  = bank_q;
                res_next.read_valid = 1'b1;
                res_next.status     = ST_NONE;
                state_next          = S_EMIT;
            end
            S_CHK:
            begin
                // last target address = pointer + data bytes - 1
                alu_a           = SUM_W'(ptr_reg);
                alu_b           = SUM_W'(cnt_reg) - SUM_W'(2);
                cnt_next        = '0;
                res_next.status = ST_COMMIT;
                state_next      = S_EMIT;
                if (cnt_reg <= CW'(1))
                begin
                    if (cnt_reg == '0)
                    begin
                        ptr_next = '0;
                    end
                end
                else if (alu_sum >= SUM_W'(BANK_SIZE))
                begin
                    res_next.status = ST_REJECT;
                end
                else
                begin
                    idx_next   = '0;
                    last_next  = AW'(cnt_reg - CW'(2));
                    state_next = S_COPY;
                end
            end
            S_COPY:
            begin
                alu_a        = SUM_W'(ptr_reg);
                alu_b        = SUM_W'(idx_reg);
                pend_rd.en   = 1'b1;
                pend_rd.addr = BYTE_W'(idx_reg) + BYTE_W'(1);
                cp_addr_next = BYTE_W'(alu_sum);
                cp_wr_next   = 1'b1;
                if (idx_reg == last_reg)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            writes_reg    <= 1'b0;
            ptr_reg       <= '0;
            cnt_reg       <= '0;
            sent_reg      <= '0;
            base_mod_reg  <= '0;
            load_base_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            cp_wr_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            writes_reg    <= writes_next;
            ptr_reg       <= ptr_next;
            cnt_reg       <= cnt_next;
            sent_reg      <= sent_next;
            base_mod_reg  <= base_mod_next;
            load_base_reg <= load_base_next;
            out_valid_reg <= out_valid_next;
            cp_wr_reg     <= cp_wr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg     <= acc_next;
        idx_reg     <= idx_next;
        last_reg    <= last_next;
        cp_addr_reg <= cp_addr_next;
        res_reg     <= res_next;
        out_reg     <= out_next;
    end

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for the I2C target register bank top level.
`timescale 1ns / 100ps

module testbench;
    import i2c_trb_pkg::*;

    localparam int BANK      = BANK_SIZE_DEF;
    localparam int ADDR_SPAN = 256;
    localparam int ITEMS     = 2000;
    localparam int LIMIT     = 1000000;
    localparam int SETTLE    = 400;
    localparam int HOLD_OFF  = 400;

    // codes the block has no use for; they must yield an empty result
    localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;

    class reg_bank_scoreboard;
        bit [BYTE_W-1:0] regs [ADDR_SPAN];
        bit [BYTE_W-1:0] wr_buf [ADDR_SPAN];   // wr_buf[0] holds the pointer
        int unsigned     rx_count;
        int unsigned     tx_count;
        bit [BYTE_W-1:0] read_base;
        bit              writing;
        result_t         expected_q[$];
        int              mismatches;
        int              checked;
        int              status_seen[8];

        task report_mismatch(input string what, input int exp_v, input int got_v);
            $display("[%0t] mismatch on result %0d: %s expected %0d got %0d",
                     $realtime, checked, what, exp_v, got_v);
            mismatches++;
        endtask

        function bit [BYTE_W-1:0] fetch(input int unsigned addr);
            return regs[(addr % BANK) % ADDR_SPAN];
        endfunction

        function logic [ST_W-1:0] commit_burst();
            logic [ST_W-1:0] st;
            int unsigned     base;
            int unsigned     n;
            int unsigned     i;
            st = ST_COMMIT;
            if (rx_count > 1) begin
                base = 32'(wr_buf[0]);
                n    = rx_count - 1;
                if (base + n - 1 >= BANK)
                    st = ST_REJECT;
                else
                    for (i = 0; i < n; i++)
                        regs[(base + i) % ADDR_SPAN] = wr_buf[(i + 1) % ADDR_SPAN];
            end
            for (i = rx_count; i < ADDR_SPAN; i++)
                wr_buf[i] = '0;
            rx_count = 0;
            return st;
        endfunction

        function result_t predict_event(input logic [OP_W-1:0] op,
                                        input logic [BYTE_W-1:0] d);
            result_t r;
            int      i;
            r = '0;
            case (op)
                OP_ADDR_WR:
                begin
                    writing   = 1'b1;
                    wr_buf[0] = '0;
                    rx_count  = 0;
                end
                OP_ADDR_RD:
                begin
                    writing      = 1'b0;
                    read_base    = wr_buf[0];
                    wr_buf[0]    = '0;
                    tx_count     = 0;
                    r.read_data  = fetch(32'(read_base));
                    r.read_valid = 1'b1;
                end
                OP_BYTE_RX:
                begin
                    if (!writing || rx_count >= BANK)
                        r.status = ST_IGNORED;
                    else
                    begin
                        wr_buf[rx_count % ADDR_SPAN] = d;
                        rx_count++;
                        if (rx_count == BANK)
                            r.status = commit_burst();
                    end
                end
                OP_BYTE_TX:
                begin
                    if (writing)
                        r.status = ST_IGNORED;
                    else
                    begin
                        tx_count++;
                        if (tx_count < BANK)
                        begin
                            r.read_data  = fetch(read_base + tx_count);
                            r.read_valid = 1'b1;
                        end
                        else
                        begin
                            tx_count = 0;
                            r.status = ST_READ_DONE;
                        end
                    end
                end
                OP_NACK_END:
                begin
                    if (writing)
                        r.status = commit_burst();
                    else
                    begin
                        tx_count = 0;
                        r.status = ST_READ_DONE;
                    end
                end
                OP_BUS_ERR:
                begin
                    for (i = 0; i < BANK; i++)
                        wr_buf[i] = '0;
                    rx_count = 0;
                    r.status = ST_BUS_ERR;
                end
                default:
                begin
                end
            endcase
            return r;
        endfunction

        function result_t note_event(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] d);
            result_t r;
            r = predict_event(op, d);
            expected_q.push_back(r);
            return r;
        endfunction

        task check_result(input logic [BYTE_W-1:0] rd, input logic rv,
                          input logic [ST_W-1:0] st);
            result_t exp_r;
            if (expected_q.size() == 0)
            begin
                report_mismatch("result with nothing outstanding, status", -1, int'(st));
            end
            else
            begin
                exp_r = expected_q.pop_front();
                if (rd !== exp_r.read_data)
                    report_mismatch("read_data", int'(exp_r.read_data), int'(rd));
                if (rv !== exp_r.read_valid)
                    report_mismatch("read_valid", int'(exp_r.read_valid), int'(rv));
                if (st !== exp_r.status)
                    report_mismatch("status", int'(exp_r.status), int'(st));
                status_seen[exp_r.status]++;
            end
            checked++;
        endtask

        function int outstanding();
            return expected_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   cycle_count;
    int   items_counted;
    int   items_sent;
    int   results_seen;
    bit   sender_calm;

    reg_bank_scoreboard sb;

    i2c_trb_in_if  req_if ();
    i2c_trb_out_if rsp_if ();

    i2c_target_register_bank_top u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // mostly back to back or short gaps, now and then a long one
    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    task automatic send_item(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] d);
        int      gap;
        result_t exp_r;
        gap = sender_calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid     <= 1'b1;
        req_if.operation <= op;
        req_if.data      <= d;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
        exp_r = sb.note_event(op, d);
        items_sent++;
        if (exp_r.status != ST_IGNORED && op <= OP_BUS_ERR)
            items_counted++;
    endtask

    function logic [BYTE_W-1:0] pick_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 8'h00;
        else if (r == 1)
            return 8'hFF;
        else
            return BYTE_W'($urandom_range(0, 255));
    endfunction

    function int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(0, 6);
        else if (r < 90)
            return $urandom_range(7, 30);
        else if (r < 96)
            return $urandom_range(120, 254);
        else
            return $urandom_range(255, 258);
    endfunction

    // pointer: random, 0, 0xFF, or one that lands on or just past the last legal start for n data bytes
    function logic [BYTE_W-1:0] pick_pointer(input int n);
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return BYTE_W'($urandom_range(0, 255));
        else if (r < 70)
            return BYTE_W'((BANK - n + $urandom_range(0, 1)) % ADDR_SPAN);
        else if (r < 85)
            return 8'h00;
        else
            return 8'hFF;
    endfunction

    task automatic write_transfer();
        int n;
        int r;
        int i;
        n = pick_length();
        send_item(OP_ADDR_WR, pick_byte());
        if ($urandom_range(0, 19) != 0)
        begin
            send_item(OP_BYTE_RX, pick_pointer(n));
            for (i = 0; i < n; i++)
                send_item(OP_BYTE_RX, pick_byte());
        end
        r = $urandom_range(0, 99);
        if (r < 80)
            send_item(OP_NACK_END, pick_byte());
        else if (r < 90)
            send_item(OP_BUS_ERR, pick_byte());
    endtask

    task automatic read_transfer();
        int k;
        int r;
        int i;
        // usually a pointer write first, then a repeated start into the read
        if ($urandom_range(0, 9) < 6)
        begin
            send_item(OP_ADDR_WR, pick_byte());
            send_item(OP_BYTE_RX, pick_byte());
        end
        r = $urandom_range(0, 99);
        if (r < 80)
            k = $urandom_range(0, 8);
        else if (r < 94)
            k = $urandom_range(9, 40);
        else
            k = $urandom_range(255, 258);
        send_item(OP_ADDR_RD, pick_byte());
        for (i = 0; i < k; i++)
            send_item(OP_BYTE_TX, pick_byte());
        r = $urandom_range(0, 99);
        if (r < 85)
            send_item(OP_NACK_END, pick_byte());
        else if (r < 92)
            send_item(OP_BUS_ERR, pick_byte());
    endtask

    task automatic noise_burst();
        int n;
        int i;
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++)
            send_item(OP_W'($urandom_range(0, 7)), BYTE_W'($urandom_range(0, 255)));
    endtask

    task automatic run_directed();
        send_item(OP_ADDR_RD, 8'h00);    // read straight out of reset
        send_item(OP_BYTE_TX, 8'hFF);
        send_item(OP_BYTE_RX, 8'hFF);    // byte received while reading
        send_item(OP_NACK_END, 8'h00);
        send_item(OP_ADDR_WR, 8'h00);
        send_item(OP_BYTE_RX, 8'hFE);    // span ends exactly on the last register
        send_item(OP_BYTE_RX, 8'hFF);
        send_item(OP_BYTE_RX, 8'h00);
        send_item(OP_NACK_END, 8'h00);
        send_item(OP_BYTE_TX, 8'h00);    // byte sent while writing
        send_item(OP_ADDR_WR, 8'h00);
        send_item(OP_BYTE_RX, 8'hFF);    // one past the end: rejected
        send_item(OP_BYTE_RX, 8'hA5);
        send_item(OP_BYTE_RX, 8'h5A);
        send_item(OP_NACK_END, 8'h00);
        send_item(OP_ADDR_WR, 8'hFF);
        send_item(OP_NACK_END, 8'hFF);   // empty write clears the whole buffer
        send_item(OP_ADDR_WR, 8'h00);
        send_item(OP_BYTE_RX, 8'hFE);    // pointer only, then repeated start
        send_item(OP_ADDR_RD, 8'h00);
        send_item(OP_BYTE_TX, 8'h00);
        send_item(OP_BYTE_TX, 8'h00);    // address wraps to register 0
        send_item(OP_BUS_ERR, 8'hFF);
        send_item(OP_UNUSED_6, 8'hFF);
        send_item(OP_UNUSED_7, 8'h00);
    endtask

    task automatic run_random();
        int r;
        int next_drain;
        next_drain = 700;
        while (items_counted < ITEMS)
        begin
            sender_calm = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 45)
                write_transfer();
            else if (r < 82)
                read_transfer();
            else
                noise_burst();
            if (items_counted >= next_drain)
            begin
                // let the block empty out before carrying on
                req_if.valid <= 1'b0;
                while (sb.outstanding() > 0) @(posedge clk);
                next_drain += 700;
            end
        end
        sender_calm = 1'b0;
    endtask

    // result side: random stalls, calm stretches, and one long hold-off
    initial
    begin
        int  stall;
        int  calm;
        int  hold_left;
        bit  hold_done;
        stall     = 0;
        calm      = 0;
        hold_left = 0;
        hold_done = 1'b0;
        rsp_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (rsp_if.valid && rsp_if.ready)
            begin
                sb.check_result(rsp_if.read_data, rsp_if.read_valid, rsp_if.status);
                results_seen++;
                if (calm > 0)
                    calm--;
                else
                    stall = pick_gap();
                if ($urandom_range(0, 49) == 0)
                    calm = $urandom_range(20, 80);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end
            else if (!hold_done && results_seen >= 300)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_OFF;
                rsp_if.ready <= 1'b0;
            end
            else if (stall > 0)
            begin
                stall--;
                rsp_if.ready <= 1'b0;
            end
            else
                rsp_if.ready <= 1'b1;
        end
    end

    initial
    begin
        cycle_count = 0;
        wait (rst_n === 1'b1);
        while (cycle_count < LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, sb.outstanding());
        $display("FAIL i2c_target_register_bank_top");
        $finish;
    end

    initial
    begin
        sb            = new;
        items_counted = 0;
        items_sent    = 0;
        results_seen  = 0;
        sender_calm   = 1'b0;
        rst_n            <= 1'b0;
        req_if.valid     <= 1'b0;
        req_if.operation <= OP_ADDR_WR;
        req_if.data      <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random();
        req_if.valid <= 1'b0;
        while (sb.outstanding() > 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        $display("%0d bus events sent (%0d not ignored), %0d results checked",
                 items_sent, items_counted, sb.checked);
        $display("commits %0d, rejected writes %0d, reads ended %0d, bus errors %0d, ignored %0d",
                 sb.status_seen[ST_COMMIT], sb.status_seen[ST_REJECT],
                 sb.status_seen[ST_READ_DONE], sb.status_seen[ST_BUS_ERR],
                 sb.status_seen[ST_IGNORED]);
        if (sb.mismatches == 0)
            $display("PASS i2c_target_register_bank_top");
        else
            $display("FAIL i2c_target_register_bank_top");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/i2c_trb_pkg.sv
rtl/i2c_trb_in_if.sv
rtl/i2c_trb_out_if.sv
rtl/i2c_trb_bank.sv
rtl/i2c_trb_pend.sv
rtl/i2c_trb_ctrl.sv
rtl/i2c_target_register_bank_top.sv
test/testbench.sv
